### src/dpcs_pkg.sv
// Package for the disc player command/status port.
// Holds item/result structs, function and command-kind codes, byte constants.
// No dependencies.
`default_nettype none

package dpcs_pkg;

    // function codes of an input item
    localparam logic [2:0] FUNC_LATCH = 3'd0;
    localparam logic [2:0] FUNC_WRITE = 3'd1;
    localparam logic [2:0] FUNC_READ  = 3'd2;
    localparam logic [2:0] FUNC_VSYNC = 3'd3;

    // decoded command kinds
    localparam logic [3:0] KIND_NONE        = 4'd0;
    localparam logic [3:0] KIND_PLAY        = 4'd1;
    localparam logic [3:0] KIND_PAUSE       = 4'd2;
    localparam logic [3:0] KIND_SKIP_FWD    = 4'd3;
    localparam logic [3:0] KIND_SKIP_BACK   = 4'd4;
    localparam logic [3:0] KIND_SEARCH_PLAY = 4'd5;
    localparam logic [3:0] KIND_REVERSE     = 4'd6;
    localparam logic [3:0] KIND_AUDIO       = 4'd7;
    localparam logic [3:0] KIND_SEARCH_HALT = 4'd8;
    localparam logic [3:0] KIND_UNSUPPORTED = 4'd9;

    // command byte patterns
    localparam logic [7:0] C0_CONTROL    = 8'h00;
    localparam logic [7:0] C0_AUDIO      = 8'h02;
    localparam logic [3:0] C0_NIB_HALT   = 4'hD;
    localparam logic [3:0] C0_NIB_SEARCH = 4'hF;
    localparam logic [7:0] C1_PLAY       = 8'h00;
    localparam logic [7:0] C1_REVERSE    = 8'h10;
    localparam logic [7:0] C1_PAUSE      = 8'h20;
    localparam logic [3:0] C1_NIB_FWD    = 4'hE;
    localparam logic [3:0] C1_NIB_BACK   = 4'hF;

    // status field markers
    localparam logic [7:0] MARK_FIRST  = 8'hF0;
    localparam logic [7:0] MARK_SECOND = 8'hA0;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  data_byte;
        logic        line_level;
        logic [16:0] current_frame;
        logic        second_field;
        logic        player_playing;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        data_available;
        logic        ready_for_command;
        logic [3:0]  command_kind;
        logic [17:0] command_number;
    } result_t;

    // per-request strobes, already qualified by the pipeline advancing
    typedef struct packed {
        logic wr_rise;
        logic rd_fall;
        logic vsync;
    } ctl_t;

    // decimal digits of the frame number; top is frame / 10000 (0..13)
    typedef struct packed {
        logic [3:0] top;
        logic [3:0] d3;
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
    } digits_t;

endpackage

`default_nettype wire

### src/dpcs_bcd.sv
// Frame number to decimal digits, three register stages.
// Uses dpcs_pkg (digits_t). Each stage is a bank of constant compares
// followed by one subtract.
`default_nettype none

module dpcs_bcd
    import dpcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [16:0] frame,
    output digits_t          digits
);

    logic [3:0]  q1_reg, q1_next;
    logic [13:0] rem1_reg, rem1_next;
    logic [3:0]  q2_reg, d3_2_reg, d3_2_next;
    logic [9:0]  rem2_reg, rem2_next;
    logic [3:0]  q3_reg, d3_3_reg, d2_3_reg, d2_3_next;
    logic [6:0]  rem3_reg, rem3_next;
    logic [16:0] base1;
    logic [13:0] base2;
    logic [9:0]  base3;
    logic [6:0]  base4;
    logic [3:0]  d1;

    // ten-thousands
    always_comb
    begin
        q1_next = 4'd0;
        base1   = 17'd0;
        for (int k = 1; k <= 13; k++)
        begin
            if (frame >= 17'(k * 10000))
            begin
                q1_next = 4'(k);
                base1   = 17'(k * 10000);
            end
        end
        rem1_next = 14'(frame - base1);
    end

    // thousands
    always_comb
    begin
        d3_2_next = 4'd0;
        base2     = 14'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem1_reg >= 14'(k * 1000))
            begin
                d3_2_next = 4'(k);
                base2     = 14'(k * 1000);
            end
        end
        rem2_next = 10'(rem1_reg - base2);
    end

    // hundreds
    always_comb
    begin
        d2_3_next = 4'd0;
        base3     = 10'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem2_reg >= 10'(k * 100))
            begin
                d2_3_next = 4'(k);
                base3     = 10'(k * 100);
            end
        end
        rem3_next = 7'(rem2_reg - base3);
    end

    // tens and units, narrow enough to finish after the last stage
    always_comb
    begin
        d1    = 4'd0;
        base4 = 7'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem3_reg >= 7'(k * 10))
            begin
                d1    = 4'(k);
                base4 = 7'(k * 10);
            end
        end
        digits.top = q3_reg;
        digits.d3  = d3_3_reg;
        digits.d2  = d2_3_reg;
        digits.d1  = d1;
        digits.d0  = 4'(rem3_reg - base4);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg   <= q1_next;
            rem1_reg <= rem1_next;
            q2_reg   <= q1_reg;
            d3_2_reg <= d3_2_next;
            rem2_reg <= rem2_next;
            q3_reg   <= q2_reg;
            d3_3_reg <= d3_2_reg;
            d2_3_reg <= d2_3_next;
            rem3_reg <= rem3_next;
        end
    end

endmodule

`default_nettype wire

### src/dpcs_cmd.sv
// Command byte assembly and decode, plus the ready flag.
// Uses dpcs_pkg (ctl_t, command codes). The BCD weight of the first two
// bytes is folded in when the second byte arrives.
`default_nettype none

module dpcs_cmd
    import dpcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctl_t        ctl,
    input  wire logic [7:0]  latch,
    input  wire logic [16:0] frame,
    input  wire logic        second,
    input  wire logic        playing,
    output logic             ready_next,
    output logic [3:0]       kind,
    output logic [17:0]      num
);

    localparam logic [1:0] BYTE_FIRST = 2'd0;
    localparam logic [1:0] BYTE_MID   = 2'd1;
    localparam logic [1:0] BYTE_LAST  = 2'd2;

    logic [1:0]  count_reg;
    logic        ready_reg;
    logic [7:0]  c0_reg;
    logic [7:0]  c1_reg;
    logic [17:0] p5_reg;   // c0 low, c1 high, c1 low weighted as a frame
    logic [10:0] p3_reg;   // c1 low weighted as hundreds of a skip

    logic [7:0]  tail;
    logic [17:0] target;
    logic [18:0] target_m1;
    logic        behind;
    logic [17:0] skip_num;
    logic        done;

    assign tail      = 8'(latch[7:4]) * 8'd10 + 8'(latch[3:0]);
    assign target    = p5_reg + 18'(tail);
    assign target_m1 = {1'b0, target} - 19'd1;
    assign behind    = (target != 18'd0) && ({2'b00, frame} < target_m1);
    assign skip_num  = 18'(p3_reg) + 18'(tail);
    assign done      = ctl.wr_rise && (count_reg == BYTE_LAST);

    assign ready_next = ready_reg | ctl.wr_rise | ctl.vsync;

    always_comb
    begin
        kind = KIND_NONE;
        num  = 18'd0;
        if (done)
        begin
            priority if (c0_reg == C0_CONTROL)
            begin
                priority if (c1_reg == C1_PLAY)
                    kind = playing ? KIND_NONE : KIND_PLAY;
                else if (c1_reg == C1_REVERSE)
                    kind = KIND_REVERSE;
                else if (c1_reg == C1_PAUSE)
                    kind = KIND_PAUSE;
                else if (c1_reg[7:4] == C1_NIB_FWD)
                begin
                    kind = KIND_SKIP_FWD;
                    num  = skip_num;
                end
                else if (c1_reg[7:4] == C1_NIB_BACK)
                begin
                    kind = KIND_SKIP_BACK;
                    num  = skip_num;
                end
                else
                    kind = KIND_UNSUPPORTED;
            end
            else if (c0_reg == C0_AUDIO)
                kind = KIND_AUDIO;
            else if (c0_reg[7:4] == C0_NIB_HALT)
                kind = KIND_SEARCH_HALT;
            else if (c0_reg[7:4] == C0_NIB_SEARCH)
            begin
                // second field and short of target: skip up to the frame before it
                if (second && behind)
                begin
                    kind = KIND_SKIP_FWD;
                    num  = 18'(target_m1 - {2'b00, frame});
                end
                else
                begin
                    kind = KIND_SEARCH_PLAY;
                    num  = target;
                end
            end
            else
                kind = KIND_UNSUPPORTED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= BYTE_FIRST;
            ready_reg <= 1'b0;
        end
        else
        begin
            ready_reg <= ready_next;
            if (ctl.vsync)
                count_reg <= BYTE_FIRST;
            else if (ctl.wr_rise)
                count_reg <= done ? BYTE_FIRST : count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_rise)
        begin
            unique case (count_reg)
                BYTE_FIRST:
                    c0_reg <= latch;
                BYTE_MID:
                begin
                    c1_reg <= latch;
                    p5_reg <= 18'(c0_reg[3:0]) * 18'd10000
                            + 18'(latch[7:4]) * 18'd1000
                            + 18'(latch[3:0]) * 18'd100;
                    p3_reg <= 11'(latch[3:0]) * 11'd100;
                end
                default:
                    ;
            endcase
        end
    end

endmodule

`default_nettype wire

### src/dpcs_status.sv
// Status record, read index and data-available flag.
// Uses dpcs_pkg (ctl_t, digits_t, markers). Only the first three bytes of
// the record can be nonzero, so only those are stored.
`default_nettype none

module dpcs_status
    import dpcs_pkg::*;
#(
    parameter int STATUS_BYTES = 6
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ctl_t       ctl,
    input  wire digits_t    digits,
    input  wire logic       second,
    output logic            avail_next,
    output logic [7:0]      rd_next
);

    localparam int IDX_W = $clog2(STATUS_BYTES + 1);

    logic [7:0]       s0_reg, s0_next;
    logic [7:0]       s1_reg, s1_next;
    logic [7:0]       s2_reg, s2_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             avail_reg;

    always_comb
    begin
        s0_next    = s0_reg;
        s1_next    = s1_reg;
        s2_next    = s2_reg;
        idx_next   = idx_reg;
        avail_next = avail_reg;
        if (ctl.vsync)
        begin
            s0_next    = (second ? MARK_SECOND : MARK_FIRST) | {4'h0, digits.top};
            s1_next    = {digits.d3, digits.d2};
            s2_next    = {digits.d1, digits.d0};
            idx_next   = '0;
            avail_next = 1'b1;
        end
        else if (ctl.rd_fall)
        begin
            // a falling strobe past the end drops data-available
            if (idx_reg < IDX_W'(STATUS_BYTES))
                idx_next = idx_reg + IDX_W'(1);
            else
                avail_next = 1'b0;
        end

        unique case (idx_next)
            IDX_W'(0): rd_next = s0_next;
            IDX_W'(1): rd_next = s1_next;
            IDX_W'(2): rd_next = s2_next;
            default:   rd_next = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg    <= 8'h00;
            s1_reg    <= 8'h00;
            s2_reg    <= 8'h00;
            idx_reg   <= '0;
            avail_reg <= 1'b0;
        end
        else
        begin
            s0_reg    <= s0_next;
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            idx_reg   <= idx_next;
            avail_reg <= avail_next;
        end
    end

endmodule

`default_nettype wire

### src/disc_player_command_status_port_unit.sv
// Disc player command/status port, top level.
// One request per cycle is accepted while result_stall does not hold the output result.
// The frame-to-decimal conversion sets the depth: three compare/subtract stages
// ahead of the stage that updates state and decodes commands.
// Reset (rst_n, async low) clears flags, counters, strobe levels, latch and status.
// Uses dpcs_pkg, dpcs_bcd, dpcs_cmd, dpcs_status.
`default_nettype none

module disc_player_command_status_port_unit
    import dpcs_pkg::*;
#(
    parameter int STATUS_BYTES = 6
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic item_valid,
    output logic      item_stall,
    input  wire item_t item,
    output logic      result_valid,
    input  wire logic result_stall,
    output result_t   result
);

    logic    en;
    logic    a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, out_valid_reg;
    item_t   a_item_reg, b_item_reg, c_item_reg, d_item_reg;
    result_t result_reg, result_next;
    logic [7:0] latch_reg;
    logic    wlev_reg;
    logic    rlev_reg;
    logic    fire;
    ctl_t    ctl;
    digits_t digits;
    logic    ready_next;
    logic    avail_next;
    logic [7:0]  rd_next;
    logic [3:0]  kind;
    logic [17:0] num;

    // whole pipeline moves together unless the held result is stalled
    assign en           = !out_valid_reg || !result_stall;
    assign item_stall   = !en;
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    assign fire = d_valid_reg && en;

    always_comb
    begin
        ctl.wr_rise = fire && (d_item_reg.func == FUNC_WRITE)
                      && d_item_reg.line_level && !wlev_reg;
        ctl.rd_fall = fire && (d_item_reg.func == FUNC_READ)
                      && !d_item_reg.line_level && rlev_reg;
        ctl.vsync   = fire && (d_item_reg.func == FUNC_VSYNC);
    end

    dpcs_bcd u_bcd (
        .clk    (clk),
        .en     (en),
        .frame  (a_item_reg.current_frame),
        .digits (digits)
    );

    dpcs_cmd u_cmd (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .latch      (latch_reg),
        .frame      (d_item_reg.current_frame),
        .second     (d_item_reg.second_field),
        .playing    (d_item_reg.player_playing),
        .ready_next (ready_next),
        .kind       (kind),
        .num        (num)
    );

    dpcs_status #(
        .STATUS_BYTES (STATUS_BYTES)
    ) u_status (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .digits     (digits),
        .second     (d_item_reg.second_field),
        .avail_next (avail_next),
        .rd_next    (rd_next)
    );

    always_comb
    begin
        result_next.read_data         = rd_next;
        result_next.data_available    = avail_next;
        result_next.ready_for_command = ready_next;
        result_next.command_kind      = kind;
        result_next.command_number    = num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            latch_reg     <= 8'h00;
            wlev_reg      <= 1'b0;
            rlev_reg      <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                a_valid_reg   <= item_valid;
                b_valid_reg   <= a_valid_reg;
                c_valid_reg   <= b_valid_reg;
                d_valid_reg   <= c_valid_reg;
                out_valid_reg <= d_valid_reg;
            end
            if (fire)
            begin
                if (d_item_reg.func == FUNC_LATCH)
                    latch_reg <= d_item_reg.data_byte;
                if (d_item_reg.func == FUNC_WRITE)
                    wlev_reg <= d_item_reg.line_level;
                if (d_item_reg.func == FUNC_READ)
                    rlev_reg <= d_item_reg.line_level;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg <= item;
            b_item_reg <= a_item_reg;
            c_item_reg <= b_item_reg;
            d_item_reg <= c_item_reg;
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire
